// ----- design/brb_pkg.sv -----
// Shared types, constants and a helper function for the bracket balance checker.
package brb_pkg;

  // Stack geometry.
  localparam int STACK_DEPTH = 64;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int LIMIT_W     = 5;
  localparam int CMP_W       = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;

  // Most leftover entries that one report can list.
  localparam logic [LIMIT_W-1:0] MAX_LISTED    = LIMIT_W'(16);
  localparam logic [LIMIT_W-1:0] LIMIT_DEFAULT = LIMIT_W'(6);

  // Characters of interest.
  localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;
  localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;
  localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;
  localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;

  // Report kinds.
  localparam logic [1:0] KIND_VALID    = 2'd0;
  localparam logic [1:0] KIND_LISTED   = 2'd1;
  localparam logic [1:0] KIND_TOO_MANY = 2'd2;

  // Stack entry codes.
  typedef enum logic [1:0] {
    CODE_ROUND_OPEN   = 2'd0,
    CODE_SQUARE_OPEN  = 2'd1,
    CODE_ROUND_CLOSE  = 2'd2,
    CODE_SQUARE_CLOSE = 2'd3
  } code_t;

  // Per-cycle command shared by every cell of the stack.
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } stack_op_t;

  // Command bundle from the controller to the stack.
  typedef struct packed {
    stack_op_t op;
    code_t     push_code;
  } stack_ctrl_t;

  // Input word.
  typedef struct packed {
    logic [7:0] symbol_char;
    logic       end_of_word;
  } in_word_t;

  // Output word.
  typedef struct packed {
    logic [1:0] report_kind;
    logic [7:0] missing_char;
    logic       last_of_report;
  } out_word_t;

  // Counterpart character of a stack entry.
  function automatic logic [7:0] partner_char(input code_t code);
    logic [7:0] ch;
    unique case (code)
      CODE_ROUND_OPEN:   ch = CHAR_ROUND_CLOSE;
      CODE_SQUARE_OPEN:  ch = CHAR_SQUARE_CLOSE;
      CODE_ROUND_CLOSE:  ch = CHAR_ROUND_OPEN;
      CODE_SQUARE_CLOSE: ch = CHAR_SQUARE_OPEN;
      default:           ch = CHAR_ROUND_OPEN;
    endcase
    return ch;
  endfunction

endpackage

// ----- design/brb_cell.sv -----
// One cell of the shifting bracket stack: holds a single entry code.
module brb_cell
  import brb_pkg::*;
(
  input  logic      clk,
  input  stack_op_t op,
  input  code_t     from_upper,
  input  code_t     from_lower,
  output code_t     code
);

  // On a push the entry moves one place down; on a pop one place up.
  always_ff @(posedge clk) begin
    unique case (op)
      OP_HOLD: code <= code;
      OP_PUSH: code <= from_upper;
      OP_POP:  code <= from_lower;
      default: code <= code;
    endcase
  end

endmodule

// ----- design/brb_stack.sv -----
// Row of cells forming the bracket stack, with the top entry in cell zero.
module brb_stack
  import brb_pkg::*;
(
  input  logic        clk,
  input  stack_ctrl_t ctrl,
  output code_t       top_code
);

  code_t cell_code [STACK_DEPTH];

  // Each cell takes its neighbours' entries; the ends see the new code or themselves.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    code_t upper;
    code_t lower;

    if (i == 0) begin : g_top
      assign upper = ctrl.push_code;
    end else begin : g_mid_up
      assign upper = cell_code[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign lower = cell_code[i];
    end else begin : g_mid_down
      assign lower = cell_code[i+1];
    end

    brb_cell u_cell (
      .clk        (clk),
      .op         (ctrl.op),
      .from_upper (upper),
      .from_lower (lower),
      .code       (cell_code[i])
    );
  end

  assign top_code = cell_code[0];

endmodule

// ----- design/bracket_balance_checker.sv -----
// Top level of the bracket balance checker: control, count and output register.
//
// Usage: one character word per accepted input (in_valid high, in_stall low).
// Round and square brackets are tracked on a stack of shifting cells; other
// characters are ignored. A word with end_of_word set closes the current text
// and starts a report on the output channel (out_valid, out_stall, out_word).
// Characters are taken one per cycle. After an end-of-word character the
// block stalls its input while the report drains: one word for "valid" or
// "too many missing", or one word per leftover entry (up to 16), top first,
// the final one with last_of_report. Once the end-of-word character is taken
// the controller enters its report state and loads the report words from there
// into the output register. A stalled output word holds, and the
// report waits. The missing limit is written through cfg_write / cfg_data.
// Reset clears the stack count, the overflow flag and any pending report,
// and sets the missing limit to 6. The stack cells themselves are not reset.
module bracket_balance_checker
  import brb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_word,
  input  logic               cfg_write,
  input  logic [LIMIT_W-1:0] cfg_data
);

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] stack_count;
  logic               overflow_flag;
  logic [LIMIT_W-1:0] missing_limit;

  stack_ctrl_t        ctrl;
  code_t              top_code;

  logic               in_accept;
  logic               out_load;
  logic               is_open;
  logic               is_close;
  logic               pop_ok;
  logic               do_push;
  logic               stack_full;
  code_t              close_code;
  code_t              want_code;
  logic [LIMIT_W-1:0] limit_eff;
  logic               too_many;

  // Stack of cells.
  brb_stack u_stack (
    .clk      (clk),
    .ctrl     (ctrl),
    .top_code (top_code)
  );

  // Handshake.
  assign in_stall  = (state == ST_REPORT);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = !out_valid || !out_stall;

  // Character decode and match against the top entry.
  assign is_open    = (in_word.symbol_char == CHAR_ROUND_OPEN) ||
                      (in_word.symbol_char == CHAR_SQUARE_OPEN);
  assign is_close   = (in_word.symbol_char == CHAR_ROUND_CLOSE) ||
                      (in_word.symbol_char == CHAR_SQUARE_CLOSE);
  assign want_code  = (in_word.symbol_char == CHAR_ROUND_CLOSE) ?
                      CODE_ROUND_OPEN : CODE_SQUARE_OPEN;
  assign close_code = (in_word.symbol_char == CHAR_ROUND_CLOSE) ?
                      CODE_ROUND_CLOSE : CODE_SQUARE_CLOSE;
  assign pop_ok     = is_close && (stack_count != '0) && (top_code == want_code);
  assign do_push    = is_open || (is_close && !pop_ok);
  assign stack_full = (stack_count == COUNT_W'(STACK_DEPTH));

  // Report decision on the count left at the end of the word.
  assign limit_eff = (missing_limit > MAX_LISTED) ? MAX_LISTED : missing_limit;
  assign too_many  = overflow_flag || (CMP_W'(stack_count) > CMP_W'(limit_eff));

  // Stack command for this cycle.
  always_comb begin
    ctrl.op        = OP_HOLD;
    ctrl.push_code = (in_word.symbol_char == CHAR_ROUND_OPEN)  ? CODE_ROUND_OPEN  :
                     (in_word.symbol_char == CHAR_SQUARE_OPEN) ? CODE_SQUARE_OPEN :
                     close_code;
    if (state == ST_IDLE) begin
      if (in_accept && pop_ok) begin
        ctrl.op = OP_POP;
      end else if (in_accept && do_push && !stack_full) begin
        ctrl.op = OP_PUSH;
      end
    end else if (out_load && !too_many && (stack_count != '0)) begin
      ctrl.op = OP_POP;
    end
  end

  // Missing limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      missing_limit <= LIMIT_DEFAULT;
    end else if (cfg_write) begin
      missing_limit <= cfg_data;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (state == ST_REPORT && out_load) begin
      if (too_many) begin
        out_word <= '{report_kind: KIND_TOO_MANY, missing_char: 8'h00,
                      last_of_report: 1'b1};
      end else if (stack_count == '0) begin
        out_word <= '{report_kind: KIND_VALID, missing_char: 8'h00,
                      last_of_report: 1'b1};
      end else begin
        out_word <= '{report_kind: KIND_LISTED, missing_char: partner_char(top_code),
                      last_of_report: (stack_count == COUNT_W'(1))};
      end
    end
  end

  // Controller: stack count, overflow, report sequencing and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      stack_count   <= '0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // Output valid rises with each report word and falls once the word is taken.
      if (state == ST_REPORT && out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (pop_ok) begin
              stack_count <= stack_count - COUNT_W'(1);
            end else if (do_push) begin
              if (stack_full) begin
                overflow_flag <= 1'b1;
              end else begin
                stack_count <= stack_count + COUNT_W'(1);
              end
            end
            if (in_word.end_of_word) begin
              state <= ST_REPORT;
            end
          end
        end
        ST_REPORT: begin
          if (out_load) begin
            if (too_many || stack_count == '0) begin
              stack_count   <= '0;
              overflow_flag <= 1'b0;
              state         <= ST_IDLE;
            end else begin
              stack_count <= stack_count - COUNT_W'(1);
              if (stack_count == COUNT_W'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- bench/tb_bracket_balance_checker.sv -----
// Self-checking testbench for the bracket balance checker with its own stack predictor.
module tb_bracket_balance_checker;
  import brb_pkg::*;

  // One row of the directed table: either a limit write or a run of characters.
  typedef struct {
    bit                 is_limit;
    logic [LIMIT_W-1:0] limit_value;
    logic [7:0]         ch;
    bit                 eow;
    int                 reps;
    bit                 typed;
    out_word_t          want;
  } stim_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_word_t           in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_word;
  logic               cfg_write = 1'b0;
  logic [LIMIT_W-1:0] cfg_data = '0;

  // Shadow copy of the block's state.
  code_t              shadow_stack [STACK_DEPTH];
  int unsigned        shadow_depth;
  bit                 shadow_overflow;
  logic [LIMIT_W-1:0] shadow_limit;

  // Report words predicted for the latest character, and those still awaited.
  out_word_t fresh_reports[$];
  out_word_t pending_reports[$];
  stim_row_t directed_rows[$];

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int counted_items   = 0;
  int mismatch_count  = 0;

  bracket_balance_checker dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous upper bound on the whole run.
  initial begin
    #2000000;
    $display("bracket_balance_checker test failed");
    $finish;
  end

  // Push one entry on the shadow stack, or note the overflow when it is full.
  function automatic void shadow_push(code_t code);
    if (shadow_depth < STACK_DEPTH) begin
      shadow_stack[shadow_depth] = code;
      shadow_depth++;
    end else begin
      shadow_overflow = 1'b1;
    end
  endfunction

  // Apply one character to the shadow state and work out the report it causes.
  function automatic void advance_brackets(in_word_t w);
    code_t       want_code;
    int unsigned eff_limit;
    out_word_t   rw;
    fresh_reports.delete();
    if (w.symbol_char == CHAR_ROUND_OPEN) begin
      shadow_push(CODE_ROUND_OPEN);
    end else if (w.symbol_char == CHAR_SQUARE_OPEN) begin
      shadow_push(CODE_SQUARE_OPEN);
    end else if (w.symbol_char == CHAR_ROUND_CLOSE || w.symbol_char == CHAR_SQUARE_CLOSE) begin
      want_code = (w.symbol_char == CHAR_ROUND_CLOSE) ? CODE_ROUND_OPEN : CODE_SQUARE_OPEN;
      if (shadow_depth > 0 && shadow_stack[shadow_depth-1] == want_code)
        shadow_depth--;
      else
        shadow_push((w.symbol_char == CHAR_ROUND_CLOSE) ? CODE_ROUND_CLOSE : CODE_SQUARE_CLOSE);
    end
    if (!w.end_of_word)
      return;
    // The listed report never holds more than sixteen words.
    eff_limit = (shadow_limit > MAX_LISTED) ? MAX_LISTED : shadow_limit;
    if (shadow_overflow || shadow_depth > eff_limit) begin
      fresh_reports.push_back('{KIND_TOO_MANY, 8'h00, 1'b1});
    end else if (shadow_depth == 0) begin
      fresh_reports.push_back('{KIND_VALID, 8'h00, 1'b1});
    end else begin
      for (int i = shadow_depth - 1; i >= 0; i--) begin
        rw.report_kind    = KIND_LISTED;
        rw.last_of_report = (i == 0);
        case (shadow_stack[i])
          CODE_ROUND_OPEN:  rw.missing_char = CHAR_ROUND_CLOSE;
          CODE_SQUARE_OPEN: rw.missing_char = CHAR_SQUARE_CLOSE;
          CODE_ROUND_CLOSE: rw.missing_char = CHAR_ROUND_OPEN;
          default:          rw.missing_char = CHAR_SQUARE_OPEN;
        endcase
        fresh_reports.push_back(rw);
      end
    end
    shadow_depth    = 0;
    shadow_overflow = 1'b0;
  endfunction

  // Directed table builders.
  function automatic void add_chars(logic [7:0] ch, int reps, bit eow);
    stim_row_t row;
    row = '{1'b0, '0, ch, eow, reps, 1'b0, '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_checked(logic [7:0] ch, logic [1:0] kind, logic [7:0] mchar);
    stim_row_t row;
    row = '{1'b0, '0, ch, 1'b1, 1, 1'b1, '{kind, mchar, 1'b1}};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_limit(logic [LIMIT_W-1:0] value);
    stim_row_t row;
    row = '{1'b1, value, 8'h00, 1'b0, 0, 1'b0, '0};
    directed_rows.push_back(row);
  endfunction

  function automatic logic [7:0] any_bracket();
    case ($urandom_range(0, 3))
      0:       return CHAR_ROUND_OPEN;
      1:       return CHAR_ROUND_CLOSE;
      2:       return CHAR_SQUARE_OPEN;
      default: return CHAR_SQUARE_CLOSE;
    endcase
  endfunction

  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CHAR_ROUND_OPEN || c == CHAR_ROUND_CLOSE ||
           c == CHAR_SQUARE_OPEN || c == CHAR_SQUARE_CLOSE);
    return c;
  endfunction

  // Offer one character, wait for it to be taken, then queue its expected report.
  task automatic send_char(input in_word_t w, input bit typed, input out_word_t want);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_brackets(w);
    counted_items++;
    if (typed && w.end_of_word)
      pending_reports.push_back(want);
    else
      foreach (fresh_reports[i]) pending_reports.push_back(fresh_reports[i]);
  endtask

  // Hold the input back until every expected report word has arrived, then let
  // the pipeline settle.
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain_reports();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_limit = value;
  endtask

  // Build one random word: mostly nested brackets with filler, sometimes noise or
  // a run long enough to overflow the stack.
  task automatic send_random_word();
    logic [7:0] chars[$];
    logic [7:0] closers[$];
    logic [7:0] c;
    int         shape;
    int         r;
    shape = $urandom_range(0, 99);
    if (shape < 3) begin
      repeat (STACK_DEPTH + $urandom_range(1, 4))
        chars.push_back(($urandom_range(0, 1) != 0) ? CHAR_ROUND_OPEN : CHAR_SQUARE_OPEN);
    end else if (shape < 20) begin
      repeat ($urandom_range(1, 12))
        chars.push_back(($urandom_range(0, 1) != 0) ? any_bracket() : 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 12)) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          if ($urandom_range(0, 1) != 0) begin
            chars.push_back(CHAR_ROUND_OPEN);
            closers.push_back(CHAR_ROUND_CLOSE);
          end else begin
            chars.push_back(CHAR_SQUARE_OPEN);
            closers.push_back(CHAR_SQUARE_CLOSE);
          end
        end else if (r < 70 && closers.size() != 0) begin
          chars.push_back(closers.pop_back());
        end else begin
          chars.push_back(filler_char());
        end
      end
      r = $urandom_range(0, 9);
      if (r < 5) begin
        while (closers.size() != 0) chars.push_back(closers.pop_back());
      end else if (r < 9) begin
        repeat ($urandom_range(0, 17)) chars.push_back(any_bracket());
      end else if (closers.size() != 0) begin
        // The first closer is of the wrong shape; the rest match.
        c = closers.pop_back();
        chars.push_back((c == CHAR_ROUND_CLOSE) ? CHAR_SQUARE_CLOSE : CHAR_ROUND_CLOSE);
        while (closers.size() != 0) chars.push_back(closers.pop_back());
      end
    end
    if (chars.size() == 0 || $urandom_range(0, 1) != 0)
      chars.push_back(filler_char());
    foreach (chars[i])
      send_char('{chars[i], (i == chars.size() - 1)}, 1'b0, '0);
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare every accepted report word with the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected report word: kind %0d char %02h last %0b",
                   out_word.report_kind, out_word.missing_char, out_word.last_of_report);
      end else begin
        want = pending_reports.pop_front();
        if (out_word.report_kind !== want.report_kind ||
            out_word.missing_char !== want.missing_char ||
            out_word.last_of_report !== want.last_of_report) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("report mismatch: expected kind %0d char %02h last %0b, ",
                     want.report_kind, want.missing_char, want.last_of_report,
                     "got kind %0d char %02h last %0b",
                     out_word.report_kind, out_word.missing_char, out_word.last_of_report);
        end
      end
    end
  end

  // Main sequence.
  initial begin
    int                 idle_plan  [4];
    int                 stall_plan [4];
    logic [LIMIT_W-1:0] limit_plan [8];
    stim_row_t          row;
    idle_plan  = '{0, 71, 0, 21};
    stall_plan = '{0, 0, 71, 21};
    limit_plan = '{5'd2, 5'd16, 5'd31, 5'd0, 5'd5, 5'd1, 5'd10, 5'd0};
    limit_plan[7] = 5'($urandom_range(0, 31));

    shadow_depth    = 0;
    shadow_overflow = 1'b0;
    shadow_limit    = LIMIT_DEFAULT;

    // Directed table, run at the reset limit of six unless a row changes it.
    add_checked("a", KIND_VALID, 8'h00);
    add_checked(CHAR_ROUND_OPEN, KIND_LISTED, CHAR_ROUND_CLOSE);
    add_checked(CHAR_SQUARE_OPEN, KIND_LISTED, CHAR_SQUARE_CLOSE);
    add_checked(CHAR_ROUND_CLOSE, KIND_LISTED, CHAR_ROUND_OPEN);
    add_checked(CHAR_SQUARE_CLOSE, KIND_LISTED, CHAR_SQUARE_OPEN);
    add_chars(CHAR_ROUND_OPEN, 1, 1'b0);
    add_checked(CHAR_ROUND_CLOSE, KIND_VALID, 8'h00);
    add_chars(CHAR_SQUARE_OPEN, 1, 1'b0);
    add_chars(CHAR_ROUND_CLOSE, 1, 1'b1);
    add_chars(8'h00, 1, 1'b0);
    add_checked(8'hFF, KIND_VALID, 8'h00);
    // One more leftover than the limit allows.
    add_chars(CHAR_ROUND_OPEN, 7, 1'b0);
    add_checked("z", KIND_TOO_MANY, 8'h00);
    // Exactly as many leftovers as the limit.
    add_chars(CHAR_SQUARE_OPEN, 6, 1'b0);
    add_chars(8'h7F, 1, 1'b1);
    // Overflow of the stack; the closing pop does not clear the overflow.
    add_chars(CHAR_ROUND_OPEN, STACK_DEPTH + 1, 1'b0);
    add_checked(CHAR_ROUND_CLOSE, KIND_TOO_MANY, 8'h00);
    // A closer of the wrong shape is stacked itself.
    add_chars(CHAR_ROUND_OPEN, 1, 1'b0);
    add_chars(CHAR_SQUARE_CLOSE, 1, 1'b1);
    // A limit of zero turns any leftover into too many missing.
    add_limit(5'd0);
    add_checked(CHAR_ROUND_OPEN, KIND_TOO_MANY, 8'h00);
    add_checked("a", KIND_VALID, 8'h00);
    // The largest limit saturates at sixteen listed words.
    add_limit(5'd31);
    add_chars(CHAR_SQUARE_OPEN, 16, 1'b0);
    add_chars(".", 1, 1'b1);
    add_chars(CHAR_ROUND_OPEN, 17, 1'b0);
    add_checked(8'h80, KIND_TOO_MANY, 8'h00);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_limit) begin
        write_limit(row.limit_value);
      end else begin
        for (int r = 0; r < row.reps; r++)
          send_char('{row.ch, row.eow && (r == row.reps - 1)}, row.typed, row.want);
      end
    end

    // Random words under each pattern of idling and stalling, two limits per pattern.
    for (int p = 0; p < 8; p++) begin
      write_limit(limit_plan[p]);
      sender_idle_pct = idle_plan[p / 2];
      stall_pct       = stall_plan[p / 2];
      counted_items   = 0;
      while (counted_items < 40) send_random_word();
    end

    drain_reports();
    stall_pct = 0;
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0)
      $display("bracket_balance_checker test passed");
    else
      $display("bracket_balance_checker test failed");
    $finish;
  end

endmodule
